// ===== design/socp_pkg.sv =====
// ---------------------------------------------------------------------------
// socp_pkg: shared types and constants for the cone projection pipeline
// Payload structs, region codes and the fixed widths of the datapath.
// ---------------------------------------------------------------------------
package socp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int MU_W          = 31;
	localparam int SQ_ROOT_W     = 32;
	localparam int SQ_REM_W      = SQ_ROOT_W + 2;
	localparam int SQ_STEPS      = 32;
	localparam int F_BITS        = 30;
	localparam int WIDE_W        = 65;

	localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		REG_BELOW  = 2'd0,
		REG_INSIDE = 2'd1,
		REG_PROJ   = 2'd2
	} region_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] in_x;
		logic signed [DATA_W-1:0] in_y;
		logic signed [DATA_W-1:0] in_z;
	} vec_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
		logic [1:0]               region;
	} vec_out_t;

endpackage

// ===== design/socp_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// socp_sqrt_cell: one digit of the integer square root chain
// Takes two radicand bits, resolves one root bit and registers the result.
// ---------------------------------------------------------------------------
module socp_sqrt_cell
	import socp_pkg::*;
#(
	parameter int PW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  logic [1:0]           pair_in,
	input  logic [SQ_REM_W-1:0]  rem_in,
	input  logic [SQ_ROOT_W-1:0] root_in,
	input  logic [PW-1:0]        side_in,
	output logic                 vld_out,
	output logic [SQ_REM_W-1:0]  rem_out,
	output logic [SQ_ROOT_W-1:0] root_out,
	output logic [PW-1:0]        side_out
);

	logic [SQ_REM_W-1:0] r2;
	logic [SQ_REM_W-1:0] trial;
	logic                ge;
	logic                vld_q;
	logic [SQ_REM_W-1:0] rem_q;
	logic [SQ_ROOT_W-1:0] root_q;
	logic [PW-1:0]       side_q;

	// trial subtract of 4*root + 1
	always_comb begin
		r2    = {rem_in[SQ_REM_W-3:0], pair_in};
		trial = {root_in, 2'b01};
		ge    = (r2 >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	// advance remainder, root and carried data
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? (r2 - trial) : r2;
			root_q <= {root_in[SQ_ROOT_W-2:0], ge};
			side_q <= side_in;
		end
	end

	assign vld_out  = vld_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;
	assign side_out = side_q;

endmodule

// ===== design/socp_div_cell.sv =====
// ---------------------------------------------------------------------------
// socp_div_cell: one quotient bit of a restoring divider chain
// Shifts in one numerator bit, trial subtracts the divisor, registers all.
// ---------------------------------------------------------------------------
module socp_div_cell
	import socp_pkg::*;
#(
	parameter int RW = 32,
	parameter int QW = 32,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic          bit_in,
	input  logic [RW-1:0] rem_in,
	input  logic [RW-1:0] den_in,
	input  logic [QW-1:0] q_in,
	input  logic [PW-1:0] side_in,
	output logic          vld_out,
	output logic [RW-1:0] rem_out,
	output logic [RW-1:0] den_out,
	output logic [QW-1:0] q_out,
	output logic [PW-1:0] side_out
);

	logic [RW:0]   r2;
	logic [RW:0]   diff;
	logic          ge;
	logic          vld_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] den_q;
	logic [QW-1:0] q_q;
	logic [PW-1:0] side_q;

	// compare shifted remainder against divisor
	always_comb begin
		r2   = {rem_in, bit_in};
		diff = r2 - {1'b0, den_in};
		ge   = (r2 >= {1'b0, den_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	// advance remainder, divisor, quotient and carried data
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[RW-1:0] : r2[RW-1:0];
			den_q  <= den_in;
			q_q    <= {q_in[QW-2:0], ge};
			side_q <= side_in;
		end
	end

	assign vld_out  = vld_q;
	assign rem_out  = rem_q;
	assign den_out  = den_q;
	assign q_out    = q_q;
	assign side_out = side_q;

endmodule

// ===== design/second_order_cone_projection.sv =====
// Throughput: one vector per cycle unless stalled; chains of one-bit cells
// (32 root cells, 30 factor cells, 33 + FRAC_BITS scale-division cells).
// A two-entry output buffer keeps input transfers going while a result waits.
// Reset: asynchronous, active low; clears all valid bits and the buffer and
// sets the scale register mu_q to 1.0.
// ---------------------------------------------------------------------------
// second_order_cone_projection: 3-vector projection onto a scaled cone
// Square root, factor division and scale division as chains of cells.
// ---------------------------------------------------------------------------
module second_order_cone_projection
	import socp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_valid,
	output logic            src_stall,
	input  vec_in_t         src_data,
	output logic            dst_valid,
	input  logic            dst_stall,
	output vec_out_t        dst_data,
	input  logic            cfg_we,
	input  logic [MU_W-1:0] cfg_wdata
);

	localparam int AW   = 32 + FRAC_BITS;
	localparam int DW   = 34 + FRAC_BITS;
	localparam int ZQ   = 33 + FRAC_BITS;
	localparam int SQ_PW = 3 * DATA_W + 128;
	localparam int FD_PW = 4 * DATA_W + 2;
	localparam int ZD_PW = ZQ + 5 * DATA_W + 2;
	localparam logic [MU_W-1:0] MU_RST = MU_W'(64'd1 << FRAC_BITS);

	logic [MU_W-1:0] mu_q;
	logic            adv;

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= MU_RST;
		end else if (cfg_we) begin
			mu_q <= cfg_wdata;
		end
	end

	// ---------------- front stages ----------------
	logic                     v_s1, v_s2, v_s3;
	logic signed [DATA_W-1:0] x_s1, y_s1, z_s1;
	logic signed [DATA_W-1:0] x_s2, y_s2, z_s2;
	logic signed [DATA_W-1:0] x_s3, y_s3, z_s3;
	logic [63:0]              xx_s2, yy_s2, u0_s2;
	logic [63:0]              sum_s3, u0_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// capture input, square the lateral parts, form z*mu, sum squares
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= src_data.in_x;
			y_s1   <= src_data.in_y;
			z_s1   <= src_data.in_z;
			xx_s2  <= 64'(x_s1 * x_s1);
			yy_s2  <= 64'(y_s1 * y_s1);
			u0_s2  <= 64'(z_s1 * $signed({1'b0, mu_q}));
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			sum_s3 <= xx_s2 + yy_s2;
			u0_s3  <= u0_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
		end
	end

	// ---------------- square root chain ----------------
	logic                 sq_vld  [0:SQ_STEPS];
	logic [SQ_REM_W-1:0]  sq_rem  [0:SQ_STEPS];
	logic [SQ_ROOT_W-1:0] sq_root [0:SQ_STEPS];
	logic [SQ_PW-1:0]     sq_side [0:SQ_STEPS];

	assign sq_vld[0]  = v_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = {x_s3, y_s3, z_s3, u0_s3, sum_s3};

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		socp_sqrt_cell #(.PW(SQ_PW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (sq_vld[i]),
			.pair_in  (sq_side[i][63-2*i -: 2]),
			.rem_in   (sq_rem[i]),
			.root_in  (sq_root[i]),
			.side_in  (sq_side[i]),
			.vld_out  (sq_vld[i+1]),
			.rem_out  (sq_rem[i+1]),
			.root_out (sq_root[i+1]),
			.side_out (sq_side[i+1])
		);
	end

	// ---------------- region decision ----------------
	logic [AW-1:0]            big_a;
	logic [63:0]              sq_u0;
	logic signed [WIDE_W-1:0] a_ext, u0_ext, a_sum;
	region_t                  reg_c;

	always_comb begin
		sq_u0  = sq_side[SQ_STEPS][127:64];
		big_a  = {sq_root[SQ_STEPS], {FRAC_BITS{1'b0}}};
		a_ext  = $signed({{(WIDE_W-AW){1'b0}}, big_a});
		u0_ext = $signed({sq_u0[63], sq_u0});
		a_sum  = a_ext + u0_ext;
		if (a_sum <= 0) begin
			reg_c = REG_BELOW;
		end else if (a_ext <= u0_ext) begin
			reg_c = REG_INSIDE;
		end else begin
			reg_c = REG_PROJ;
		end
	end

	logic                     v_s4;
	logic [DW-1:0]            num_s4, den_s4;
	logic [SQ_ROOT_W-1:0]     a_s4;
	logic signed [DATA_W-1:0] x_s4, y_s4, z_s4;
	region_t                  reg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_vld[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4 <= a_sum[DW-1:0];
			den_s4 <= {1'b0, big_a, 1'b0};
			a_s4   <= sq_root[SQ_STEPS];
			x_s4   <= sq_side[SQ_STEPS][223:192];
			y_s4   <= sq_side[SQ_STEPS][191:160];
			z_s4   <= sq_side[SQ_STEPS][159:128];
			reg_s4 <= reg_c;
		end
	end

	// ---------------- factor division chain ----------------
	logic              fd_vld  [0:F_BITS];
	logic [DW-1:0]     fd_rem  [0:F_BITS];
	logic [DW-1:0]     fd_den  [0:F_BITS];
	logic [F_BITS-1:0] fd_q    [0:F_BITS];
	logic [FD_PW-1:0]  fd_side [0:F_BITS];

	assign fd_vld[0]  = v_s4;
	assign fd_rem[0]  = num_s4;
	assign fd_den[0]  = den_s4;
	assign fd_q[0]    = '0;
	assign fd_side[0] = {x_s4, y_s4, z_s4, a_s4, reg_s4};

	for (genvar i = 0; i < F_BITS; i++) begin : g_fd
		socp_div_cell #(.RW(DW), .QW(F_BITS), .PW(FD_PW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (fd_vld[i]),
			.bit_in   (1'b0),
			.rem_in   (fd_rem[i]),
			.den_in   (fd_den[i]),
			.q_in     (fd_q[i]),
			.side_in  (fd_side[i]),
			.vld_out  (fd_vld[i+1]),
			.rem_out  (fd_rem[i+1]),
			.den_out  (fd_den[i+1]),
			.q_out    (fd_q[i+1]),
			.side_out (fd_side[i+1])
		);
	end

	// ---------------- scaling, rounding ----------------
	logic                     v_s5, v_s6, v_s7;
	logic signed [62:0]       px_s5, py_s5;
	logic [62:0]              pa_s5;
	logic signed [DATA_W-1:0] x_s5, y_s5, z_s5, x_s6, y_s6, z_s6, x_s7, y_s7, z_s7;
	logic [1:0]               reg_s5, reg_s6, reg_s7;
	logic [DATA_W-1:0]        ox_s6, oy_s6, t_s6, ox_s7, oy_s7;
	logic [ZQ-1:0]            numz_s7;
	logic signed [DATA_W:0]   f_sx;
	logic signed [62:0]       rx, ry;
	logic [62:0]              ra;

	assign f_sx = $signed({3'b000, fd_q[F_BITS]});

	always_comb begin
		rx = px_s5 + 63'sd536870912;
		ry = py_s5 + 63'sd536870912;
		ra = pa_s5 + 63'd536870912;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s5 <= fd_vld[F_BITS];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// multiply by factor, round half up, build scale-division numerator
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s5    <= fd_side[F_BITS][129:98];
			y_s5    <= fd_side[F_BITS][97:66];
			z_s5    <= fd_side[F_BITS][65:34];
			reg_s5  <= fd_side[F_BITS][1:0];
			px_s5   <= 63'($signed(fd_side[F_BITS][129:98]) * f_sx);
			py_s5   <= 63'($signed(fd_side[F_BITS][97:66]) * f_sx);
			pa_s5   <= 63'(fd_side[F_BITS][33:2] * fd_q[F_BITS]);
			ox_s6   <= rx[61:30];
			oy_s6   <= ry[61:30];
			t_s6    <= ra[61:30];
			x_s6    <= x_s5;
			y_s6    <= y_s5;
			z_s6    <= z_s5;
			reg_s6  <= reg_s5;
			numz_s7 <= {1'b0, t_s6, {FRAC_BITS{1'b0}}} + ZQ'(mu_q >> 1);
			ox_s7   <= ox_s6;
			oy_s7   <= oy_s6;
			x_s7    <= x_s6;
			y_s7    <= y_s6;
			z_s7    <= z_s6;
			reg_s7  <= reg_s6;
		end
	end

	// ---------------- scale division chain ----------------
	logic              zd_vld  [0:ZQ];
	logic [DATA_W-1:0] zd_rem  [0:ZQ];
	logic [DATA_W-1:0] zd_den  [0:ZQ];
	logic [ZQ-1:0]     zd_q    [0:ZQ];
	logic [ZD_PW-1:0]  zd_side [0:ZQ];

	assign zd_vld[0]  = v_s7;
	assign zd_rem[0]  = '0;
	assign zd_den[0]  = {1'b0, mu_q};
	assign zd_q[0]    = '0;
	assign zd_side[0] = {numz_s7, ox_s7, oy_s7, x_s7, y_s7, z_s7, reg_s7};

	for (genvar i = 0; i < ZQ; i++) begin : g_zd
		socp_div_cell #(.RW(DATA_W), .QW(ZQ), .PW(ZD_PW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (zd_vld[i]),
			.bit_in   (zd_side[i][ZD_PW-1-i]),
			.rem_in   (zd_rem[i]),
			.den_in   (zd_den[i]),
			.q_in     (zd_q[i]),
			.side_in  (zd_side[i]),
			.vld_out  (zd_vld[i+1]),
			.rem_out  (zd_rem[i+1]),
			.den_out  (zd_den[i+1]),
			.q_out    (zd_q[i+1]),
			.side_out (zd_side[i+1])
		);
	end

	// ---------------- result select ----------------
	logic [ZD_PW-1:0]  zs;
	logic [DATA_W-1:0] oz_sat;
	vec_out_t          res_c;
	logic              fin_vld_s8;
	vec_out_t          fin_s8;

	always_comb begin
		zs     = zd_side[ZQ];
		oz_sat = (|zd_q[ZQ][ZQ-1:DATA_W-1]) ? SAT_MAX : {1'b0, zd_q[ZQ][DATA_W-2:0]};
		res_c  = '0;
		unique case (region_t'(zs[1:0]))
			REG_BELOW: begin
				res_c.region = REG_BELOW;
			end
			REG_INSIDE: begin
				res_c.out_x  = zs[97:66];
				res_c.out_y  = zs[65:34];
				res_c.out_z  = zs[33:2];
				res_c.region = REG_INSIDE;
			end
			REG_PROJ: begin
				res_c.out_x  = zs[161:130];
				res_c.out_y  = zs[129:98];
				res_c.out_z  = oz_sat;
				res_c.region = REG_PROJ;
			end
			default: begin
				res_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s8 <= 1'b0;
		end else if (adv) begin
			fin_vld_s8 <= zd_vld[ZQ];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_s8 <= res_c;
		end
	end

	// ---------------- output buffer ----------------
	vec_out_t   buf_q [0:1];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign adv       = !(fin_vld_s8 && (cnt_q == 2'd2));
	assign src_stall = !adv;
	assign push      = adv && fin_vld_s8;
	assign pop       = dst_valid && !dst_stall;
	assign dst_valid = (cnt_q != 2'd0);
	assign dst_data  = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= fin_s8;
		end
	end

endmodule

// ===== design/socp_checker.sv =====
// ---------------------------------------------------------------------------
// socp_checker: port-level checks for the cone projection block
// Watches both channels and the result codes; bound to the top level.
// ---------------------------------------------------------------------------
module socp_checker
	import socp_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     src_valid,
	input logic     src_stall,
	input vec_in_t  src_data,
	input logic     dst_valid,
	input logic     dst_stall,
	input vec_out_t dst_data
);

	// hold a stalled result
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("stalled result changed");

	// stall the input only while a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> dst_valid)
		else $error("input stalled with no result pending");

	// below the cone all components are zero
	a_below_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.region == REG_BELOW |->
		dst_data.out_x == 0 && dst_data.out_y == 0 && dst_data.out_z == 0)
		else $error("below-cone result not zero");

	// projected axial component is never negative
	a_proj_z: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.region == REG_PROJ |-> !dst_data.out_z[31])
		else $error("projected axial component negative");

endmodule

bind second_order_cone_projection socp_checker u_socp_checker (.*);
